FILE: rtl/bxf_pkg.sv
// Shared types and constants for the 3x3 box filter stream.
// No dependencies; all rtl/ files but bxf_in_if and bxf_ram use it.
`timescale 1ns / 1ps

package bxf_pkg;

  // Configuration port layout.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 4'd1;

  localparam int ROW_WIDTH_W  = 11;
  localparam int IMAGE_ROWS_W = 16;
  localparam int ROW_WIDTH_RST  = 16;
  localparam int IMAGE_ROWS_RST = 16;
  localparam int MIN_DIM        = 3;

  // Pixel index modulo 32.
  localparam int INDEX_W = 5;

  // Reciprocal of 9 with 24 fraction bits, round(2^24 / 9).
  localparam int                 RECIP_W     = 21;
  localparam int                 RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP9      = 21'd1864135;

  // Control handed from the pipeline to each window column cell.
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

FILE: rtl/bxf_in_if.sv
// Pixel input channel: valid/ready handshake with one signed sample.
// Depends on nothing.
`timescale 1ns / 1ps

interface bxf_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

FILE: rtl/bxf_out_if.sv
// Result channel: valid/ready handshake with the window mean and tags.
// Depends on bxf_pkg for the index width.
`timescale 1ns / 1ps

interface bxf_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_BITS-1:0]  window_mean;
  logic                           window_valid;
  logic [bxf_pkg::INDEX_W-1:0]    index_mod32;
  logic                           frame_last;

  modport source (output valid, output window_mean, output window_valid,
                  output index_mod32, output frame_last, input ready);
  modport sink   (input valid, input window_mean, input window_valid,
                  input index_mod32, input frame_last, output ready);
endinterface

FILE: rtl/bxf_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on bxf_pkg for the field widths.
`timescale 1ns / 1ps

interface bxf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bxf_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [bxf_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: rtl/box_filter_3x3_stream.sv
// 3x3 box (mean) filter over a raster-order pixel stream.
// Depends on bxf_pkg, the channel interfaces, bxf_ram and bxf_col_cell.
`timescale 1ns / 1ps
//
// Usage:
//   in_if   : one signed Q8.8 pixel per item, raster order, row by row.
//   out_if  : one result item per input item, in order: the rounded mean of
//             the 3x3 window ending at that pixel (centre one row up, one
//             column left), window_valid for interior centres (mean is zero
//             otherwise), the pixel index modulo 32 and a frame-last flag.
//   cfg_if  : index 0 = row_width, index 1 = image_rows; always ready. Either
//             write restarts the frame (counters and window clear; line
//             stores keep their data). Write only while the block is empty.
// Throughput: one item per cycle while the output is not stalled; the line
//   stores are dual-port RAMs read at accept and written as the item leaves
//   stage 1, so every unstalled cycle can take a pixel.
// Stall: the whole pipeline holds while the output register is full and
//   out_if.ready is low; in_if.ready is low only then.
// Reset: synchronous, active low; row_width and image_rows return to 16,
//   counters and window columns clear, line store contents are undefined.

module box_filter_3x3_stream #(
  parameter int MAX_ROW_WIDTH = 1024,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  bxf_in_if.sink     in_if,
  bxf_out_if.source  out_if,
  bxf_cfg_if.sink    cfg_if
);

  localparam int ADDR_W = $clog2(MAX_ROW_WIDTH);
  localparam int CSUM_W = SAMPLE_BITS + 2;
  localparam int HIST_W = SAMPLE_BITS + 3;
  localparam int SUM_W  = SAMPLE_BITS + 4;
  localparam int PROD_W = SUM_W + bxf_pkg::RECIP_W + 1;
  localparam int QUO_W  = PROD_W - bxf_pkg::RECIP_SHIFT;
  localparam int IDX_W  = bxf_pkg::INDEX_W;
  localparam int ROWS_W = bxf_pkg::IMAGE_ROWS_W;

  localparam logic [ADDR_W-1:0] W_LAST_MAX = ADDR_W'(MAX_ROW_WIDTH - 1);
  localparam logic [ADDR_W-1:0] W_LAST_MIN = ADDR_W'(bxf_pkg::MIN_DIM - 1);
  localparam logic [ADDR_W-1:0] W_LAST_RST =
    (bxf_pkg::ROW_WIDTH_RST > MAX_ROW_WIDTH) ? ADDR_W'(MAX_ROW_WIDTH - 1)
                                             : ADDR_W'(bxf_pkg::ROW_WIDTH_RST - 1);
  localparam logic [ROWS_W-1:0] H_LAST_MIN = ROWS_W'(bxf_pkg::MIN_DIM - 1);
  localparam logic [ROWS_W-1:0] H_LAST_RST = ROWS_W'(bxf_pkg::IMAGE_ROWS_RST - 1);
  localparam logic [ROWS_W-1:0] ROW_TWO    = ROWS_W'(2);
  localparam logic [ADDR_W-1:0] COL_TWO    = ADDR_W'(2);

  localparam logic signed [bxf_pkg::RECIP_W:0] RECIP_S = {1'b0, bxf_pkg::RECIP9};
  localparam logic signed [PROD_W-1:0] ROUND_BIAS =
    {{(PROD_W - bxf_pkg::RECIP_SHIFT){1'b0}}, 1'b1, {(bxf_pkg::RECIP_SHIFT - 1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Tags that travel with each item down the pipeline.
  typedef struct packed {
    logic             win_valid;
    logic [IDX_W-1:0] idx;
    logic             last;
  } tag_t;

  // ---------------------------------------------------------------------
  // Configuration: store the clamped last column and last row
  // ---------------------------------------------------------------------
  logic                               cfg_wr;
  logic [bxf_pkg::ROW_WIDTH_W-1:0]    cfg_rw;
  logic [ROWS_W-1:0]                  cfg_ih;
  logic [ADDR_W-1:0]                  w_last_r, w_last_nxt;
  logic [ROWS_W-1:0]                  h_last_r, h_last_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg_wr       = cfg_if.valid;
  assign cfg_rw       = cfg_if.wdata[bxf_pkg::ROW_WIDTH_W-1:0];
  assign cfg_ih       = cfg_if.wdata[ROWS_W-1:0];

  always_comb begin
    w_last_nxt = w_last_r;
    h_last_nxt = h_last_r;
    if (cfg_wr && cfg_if.reg_index == bxf_pkg::REG_ROW_WIDTH) begin
      priority if (32'(cfg_rw) < bxf_pkg::MIN_DIM) begin
        w_last_nxt = W_LAST_MIN;
      end else if (32'(cfg_rw) > MAX_ROW_WIDTH) begin
        w_last_nxt = W_LAST_MAX;
      end else begin
        w_last_nxt = ADDR_W'(cfg_rw - 1'b1);
      end
    end
    if (cfg_wr && cfg_if.reg_index == bxf_pkg::REG_IMAGE_ROWS) begin
      if (32'(cfg_ih) < bxf_pkg::MIN_DIM) begin
        h_last_nxt = H_LAST_MIN;
      end else begin
        h_last_nxt = cfg_ih - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= W_LAST_RST;
      h_last_r <= H_LAST_RST;
    end else begin
      w_last_r <= w_last_nxt;
      h_last_r <= h_last_nxt;
    end
  end

  // Only known indexes restart the frame.
  logic restart;
  assign restart = cfg_wr && (cfg_if.reg_index == bxf_pkg::REG_ROW_WIDTH ||
                              cfg_if.reg_index == bxf_pkg::REG_IMAGE_ROWS);

  // ---------------------------------------------------------------------
  // Handshake: the whole pipeline advances unless the output is stuck
  // ---------------------------------------------------------------------
  logic adv, in_fire;
  logic out_v_r;
  logic p1_v_r, p2_v_r, p3_v_r, p4_v_r;

  assign adv         = !out_v_r || out_if.ready;
  assign in_if.ready = adv;
  assign in_fire     = in_if.valid && adv;

  // ---------------------------------------------------------------------
  // Raster position counters, sampled at accept
  // ---------------------------------------------------------------------
  logic [ADDR_W-1:0] col_r, col_nxt;
  logic [ROWS_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  tag_t              tag_in;

  assign tag_in.win_valid = (row_r >= ROW_TWO) && (col_r >= COL_TWO);
  assign tag_in.idx       = idx_r;
  assign tag_in.last      = (row_r >= h_last_r) && (col_r == w_last_r);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    idx_nxt = idx_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
      idx_nxt = '0;
    end else if (in_fire) begin
      if (tag_in.last) begin
        col_nxt = '0;
        row_nxt = '0;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
        if (col_r == w_last_r) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      idx_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      idx_r <= idx_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: line store read data arrives; write back the rolled column
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] p1_pix_r;
  logic [ADDR_W-1:0]             p1_col_r;
  tag_t                          p1_tag_r;
  logic [SAMPLE_BITS-1:0]        up_rd, mid_rd;
  logic                          p1_adv;

  assign p1_adv = p1_v_r && adv;

  bxf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_ROW_WIDTH)) u_line_upper (
    .clk   (clk),
    .we    (p1_adv),
    .waddr (p1_col_r),
    .wdata (mid_rd),
    .re    (in_fire),
    .raddr (col_r),
    .rdata (up_rd)
  );

  bxf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_ROW_WIDTH)) u_line_middle (
    .clk   (clk),
    .we    (p1_adv),
    .waddr (p1_col_r),
    .wdata (p1_pix_r),
    .re    (in_fire),
    .raddr (col_r),
    .rdata (mid_rd)
  );

  // Window column cells: cell 0 holds the previous column, cell 1 the one
  // before. Shift on every item leaving stage 1, clear on restart.
  bxf_pkg::cell_ctl_t            cell_ctl;
  logic signed [SAMPLE_BITS-1:0] col_now  [3];
  logic signed [SAMPLE_BITS-1:0] col_prev [3];
  logic signed [CSUM_W-1:0]      csum_now;
  logic signed [CSUM_W-1:0]      csum_prev, csum_prev2;

  assign cell_ctl.clear = restart;
  assign cell_ctl.shift = p1_adv;
  assign col_now[0]     = up_rd;
  assign col_now[1]     = mid_rd;
  assign col_now[2]     = p1_pix_r;

  bxf_col_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cell_ctl),
    .col_in  (col_now),
    .col_out (col_prev),
    .sum_in  (csum_now),
    .sum_out (csum_prev)
  );

  bxf_col_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cell_ctl),
    .col_in  (col_prev),
    .col_out (),
    .sum_in  (),
    .sum_out (csum_prev2)
  );

  // ---------------------------------------------------------------------
  // Stages 2..4 and output register: sum columns, scale by 1/9, round, saturate
  // ---------------------------------------------------------------------
  logic signed [CSUM_W-1:0]      p2_csum_r;
  logic signed [HIST_W-1:0]      p2_hist_r, p2_hist_nxt;
  tag_t                          p2_tag_r;
  logic signed [SUM_W-1:0]       p3_sum_r, p3_sum_nxt;
  tag_t                          p3_tag_r;
  logic signed [PROD_W-1:0]      p4_prod_r, p4_prod_nxt;
  tag_t                          p4_tag_r;
  logic signed [PROD_W-1:0]      rounded;
  logic signed [QUO_W-1:0]       quo;
  logic signed [SAMPLE_BITS-1:0] mean_nxt;
  logic signed [SAMPLE_BITS-1:0] out_mean_r;
  tag_t                          out_tag_r;

  assign p2_hist_nxt = HIST_W'(csum_prev) + HIST_W'(csum_prev2);
  assign p3_sum_nxt  = SUM_W'(p2_csum_r) + SUM_W'(p2_hist_r);
  assign p4_prod_nxt = p3_sum_r * RECIP_S;
  assign rounded     = p4_prod_r + ROUND_BIAS;
  assign quo         = QUO_W'(rounded >>> bxf_pkg::RECIP_SHIFT);

  // Saturate when the bits above the sample's sign disagree with it.
  always_comb begin
    priority if (!p4_tag_r.win_valid) begin
      mean_nxt = '0;
    end else if (quo[QUO_W-1:SAMPLE_BITS-1] == '0 ||
                 quo[QUO_W-1:SAMPLE_BITS-1] == '1) begin
      mean_nxt = quo[SAMPLE_BITS-1:0];
    end else if (quo[QUO_W-1]) begin
      mean_nxt = SAT_MIN;
    end else begin
      mean_nxt = SAT_MAX;
    end
  end

  // Valid bits: advance together, bubble where no item entered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      p3_v_r  <= 1'b0;
      p4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r  <= in_fire;
      p2_v_r  <= p1_v_r;
      p3_v_r  <= p2_v_r;
      p4_v_r  <= p3_v_r;
      out_v_r <= p4_v_r;
    end
  end

  // Payload: hold while stalled.
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_pix_r   <= in_if.pixel_in;
      p1_col_r   <= col_r;
      p1_tag_r   <= tag_in;
      p2_csum_r  <= csum_now;
      p2_hist_r  <= p2_hist_nxt;
      p2_tag_r   <= p1_tag_r;
      p3_sum_r   <= p3_sum_nxt;
      p3_tag_r   <= p2_tag_r;
      p4_prod_r  <= p4_prod_nxt;
      p4_tag_r   <= p3_tag_r;
      out_mean_r <= mean_nxt;
      out_tag_r  <= p4_tag_r;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.window_mean  = out_mean_r;
  assign out_if.window_valid = out_tag_r.win_valid;
  assign out_if.index_mod32  = out_tag_r.idx;
  assign out_if.frame_last   = out_tag_r.last;

endmodule

FILE: rtl/bxf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module bxf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bxf_col_cell.sv
// One window column cell: holds a three-sample column and its sum.
// Depends on bxf_pkg (cell_ctl_t).
`timescale 1ns / 1ps

module bxf_col_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bxf_pkg::cell_ctl_t              ctl,
  input  logic signed [SAMPLE_BITS-1:0]   col_in  [3],
  output logic signed [SAMPLE_BITS-1:0]   col_out [3],
  output logic signed [SAMPLE_BITS+1:0]   sum_in,
  output logic signed [SAMPLE_BITS+1:0]   sum_out
);

  localparam int SUM_W = SAMPLE_BITS + 2;

  logic signed [SAMPLE_BITS-1:0] col_r [3];
  logic signed [SUM_W-1:0]       sum_r;
  logic signed [SUM_W-1:0]       sum_nxt;

  // Sum of the column entering the cell.
  assign sum_nxt = SUM_W'(col_in[0]) + SUM_W'(col_in[1]) + SUM_W'(col_in[2]);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int i = 0; i < 3; i++) begin
        col_r[i] <= '0;
      end
      sum_r <= '0;
    end else if (ctl.shift) begin
      for (int i = 0; i < 3; i++) begin
        col_r[i] <= col_in[i];
      end
      sum_r <= sum_nxt;
    end
  end

  assign col_out = col_r;
  assign sum_in  = sum_nxt;
  assign sum_out = sum_r;

endmodule

FILE: rtl/bxf_checker.sv
// Port-level checks for the box filter stream, bound to the top level.
// Depends on bxf_pkg and box_filter_3x3_stream.
`timescale 1ns / 1ps

module bxf_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [SAMPLE_BITS-1:0]     out_mean,
  input logic                              out_win_valid,
  input logic [bxf_pkg::INDEX_W-1:0]       out_idx,
  input logic                              out_last,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [bxf_pkg::CFG_IDX_W-1:0]     cfg_index
);

  logic                        out_fire;
  logic                        cfg_restart;
  logic [bxf_pkg::INDEX_W-1:0] exp_idx_r, exp_idx_nxt;

  assign out_fire    = out_valid && out_ready;
  assign cfg_restart = cfg_valid && cfg_ready &&
                       (cfg_index == bxf_pkg::REG_ROW_WIDTH ||
                        cfg_index == bxf_pkg::REG_IMAGE_ROWS);

  // Track the expected pixel index of the next result.
  always_comb begin
    exp_idx_nxt = exp_idx_r;
    if (cfg_restart) begin
      exp_idx_nxt = '0;
    end else if (out_fire) begin
      exp_idx_nxt = out_last ? '0 : exp_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else begin
      exp_idx_r <= exp_idx_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean) &&
                                $stable(out_win_valid) && $stable(out_idx))
    else $error("result changed while stalled");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without an output stall");

  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_win_valid |-> out_mean == '0)
    else $error("border result carries a nonzero mean");

  a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> out_idx == exp_idx_r)
    else $error("pixel index out of sequence");

  a_last_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_win_valid)
    else $error("final pixel of a frame not marked interior");

endmodule

bind box_filter_3x3_stream bxf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_bxf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_mean      (out_if.window_mean),
  .out_win_valid (out_if.window_valid),
  .out_idx       (out_if.index_mod32),
  .out_last      (out_if.frame_last),
  .cfg_valid     (cfg_if.valid),
  .cfg_ready     (cfg_if.ready),
  .cfg_index     (cfg_if.reg_index)
);
